FILE: sv/b64d_pkg.sv
package b64d_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int CAP_W           = 16;
  localparam int CHAR_W          = 8;
  localparam int BYTE_W          = 8;
  localparam int STAT_W          = 3;
  localparam int BC_W            = 16;
  localparam int S_TDATA_W       = 8;
  localparam int M_TDATA_W       = 32;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [CAP_W-1:0]  CAPACITY_RST = 16'hffff;
  localparam logic [CHAR_W-1:0] NUL_CHAR     = 8'd0;
  localparam logic [CHAR_W-1:0] PAD_CHAR     = 8'd61;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_ONLY = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_CHAR   = 3'd1;
  localparam logic [STAT_W-1:0] ST_CAPACITY   = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD_PAD    = 3'd3;
  localparam logic [STAT_W-1:0] ST_LEFTOVER   = 3'd4;
  localparam logic [STAT_W-1:0] ST_INCOMPLETE = 3'd5;

  typedef enum logic [1:0] {
    KIND_END  = 2'd0,
    KIND_PAD  = 2'd1,
    KIND_DATA = 2'd2,
    KIND_BAD  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [5:0] sextet;
  } entry_t;

  typedef enum logic [2:0] {
    PM_DECODE = 3'b001,
    PM_AWAIT  = 3'b010,
    PM_TAIL   = 3'b100
  } pad_state_t;

  function automatic logic is_space(logic [CHAR_W-1:0] c);
    return (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
  endfunction

  // {valid, value}
  function automatic logic [6:0] sextet_of(logic [CHAR_W-1:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c >= 8'd65 && c <= 8'd90) begin
      r = {1'b1, 6'(c - 8'd65)};
    end else if (c >= 8'd97 && c <= 8'd122) begin
      r = {1'b1, 6'(c - 8'd71)};
    end else if (c >= 8'd48 && c <= 8'd57) begin
      r = {1'b1, 6'(c + 8'd4)};
    end else if (c == 8'd43) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'd47) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

FILE: sv/b64d_front.sv
module b64d_front (
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [b64d_pkg::S_TDATA_W-1:0]        s_tdata,
  input  logic                                  q_full,
  output logic                                  q_push,
  output b64d_pkg::entry_t                      q_entry
);

  logic [6:0] sx;

  always_comb begin
    sx = b64d_pkg::sextet_of(s_tdata);
    q_entry.sextet = sx[5:0];
    if (s_tdata == b64d_pkg::NUL_CHAR) begin
      q_entry.kind = b64d_pkg::KIND_END;
    end else if (s_tdata == b64d_pkg::PAD_CHAR) begin
      q_entry.kind = b64d_pkg::KIND_PAD;
    end else if (sx[6]) begin
      q_entry.kind = b64d_pkg::KIND_DATA;
    end else begin
      q_entry.kind = b64d_pkg::KIND_BAD;
    end
  end

  // whitespace never touches decoder state: dropped here
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full && !b64d_pkg::is_space(s_tdata);

endmodule

FILE: sv/b64d_queue.sv
module b64d_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  b64d_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output b64d_pkg::entry_t head
);

  localparam int PTR_W = (b64d_pkg::QUEUE_DEPTH > 1) ? $clog2(b64d_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(b64d_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(b64d_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(b64d_pkg::QUEUE_DEPTH);

  b64d_pkg::entry_t slots [b64d_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == DEPTH_C);
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: sv/b64d_back.sv
module b64d_back #(
  parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  b64d_pkg::entry_t                  q_head,
  output logic                              q_pop,
  input  logic [b64d_pkg::CAP_W-1:0]        capacity,
  input  logic                              count_only,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [b64d_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic                              m_tuser,
  output logic                              m_tlast
);

  localparam int CMP_W = ((COUNT_WIDTH > b64d_pkg::CAP_W) ? COUNT_WIDTH : b64d_pkg::CAP_W) + 1;
  localparam int PAY_W = b64d_pkg::BC_W + b64d_pkg::STAT_W + b64d_pkg::BYTE_W;

  logic [1:0]                    phase, phase_next;
  b64d_pkg::pad_state_t          pad, pad_next;
  logic [7:0]                    partial, partial_next;
  logic [COUNT_WIDTH-1:0]        out_count, out_count_next, count_bump;
  logic [b64d_pkg::STAT_W-1:0]   err, err_next;

  logic                          step;
  logic                          emit, emit_status;
  logic [7:0]                    emit_byte;
  logic [b64d_pkg::STAT_W-1:0]   final_err;
  logic [CMP_W-1:0]              need_ext, cap_ext;
  logic                          cap_fail;

  logic                          out_user;
  logic [b64d_pkg::BYTE_W-1:0]   out_byte;
  logic [b64d_pkg::STAT_W-1:0]   out_status;
  logic [b64d_pkg::BC_W-1:0]     out_bc;

  assign step  = q_valid && (!m_tvalid || m_tready);
  assign q_pop = step;

  // phases 1 and 2 store a byte now and another before the quantum ends
  assign need_ext   = CMP_W'(out_count) + CMP_W'(phase == 2'd1 || phase == 2'd2);
  assign cap_ext    = CMP_W'(capacity);
  assign cap_fail   = !count_only && (need_ext >= cap_ext);
  assign count_bump = (&out_count) ? out_count : out_count + 1'b1;

  always_comb begin
    phase_next     = phase;
    pad_next       = pad;
    partial_next   = partial;
    out_count_next = out_count;
    err_next       = err;
    emit           = 1'b0;
    emit_status    = 1'b0;
    emit_byte      = 8'd0;
    final_err      = err;
    if (step) begin
      if (q_head.kind == b64d_pkg::KIND_END) begin
        if (err == b64d_pkg::ST_OK) begin
          unique case (pad)
            b64d_pkg::PM_DECODE: begin
              if (phase != 2'd0) final_err = b64d_pkg::ST_INCOMPLETE;
            end
            b64d_pkg::PM_AWAIT: final_err = b64d_pkg::ST_BAD_PAD;
            b64d_pkg::PM_TAIL: begin
              if (!count_only && partial != 8'd0) final_err = b64d_pkg::ST_LEFTOVER;
            end
            default: final_err = err;
          endcase
        end
        emit           = 1'b1;
        emit_status    = 1'b1;
        phase_next     = 2'd0;
        pad_next       = b64d_pkg::PM_DECODE;
        partial_next   = 8'd0;
        out_count_next = '0;
        err_next       = b64d_pkg::ST_OK;
      end else if (err == b64d_pkg::ST_OK) begin
        unique case (pad)
          b64d_pkg::PM_AWAIT: begin
            if (q_head.kind == b64d_pkg::KIND_PAD) pad_next = b64d_pkg::PM_TAIL;
            else err_next = b64d_pkg::ST_BAD_PAD;
          end
          b64d_pkg::PM_TAIL: err_next = b64d_pkg::ST_BAD_PAD;
          b64d_pkg::PM_DECODE: begin
            unique case (q_head.kind)
              b64d_pkg::KIND_PAD: begin
                if (phase == 2'd2) pad_next = b64d_pkg::PM_AWAIT;
                else if (phase == 2'd3) pad_next = b64d_pkg::PM_TAIL;
                else err_next = b64d_pkg::ST_BAD_PAD;
              end
              b64d_pkg::KIND_BAD: err_next = b64d_pkg::ST_BAD_CHAR;
              b64d_pkg::KIND_DATA: begin
                if (cap_fail) begin
                  err_next = b64d_pkg::ST_CAPACITY;
                end else begin
                  phase_next = phase + 2'd1;
                  case (phase)
                    2'd0: partial_next = {q_head.sextet, 2'b00};
                    2'd1: begin
                      emit_byte    = partial | {6'd0, q_head.sextet[5:4]};
                      partial_next = {q_head.sextet[3:0], 4'd0};
                    end
                    2'd2: begin
                      emit_byte    = partial | {4'd0, q_head.sextet[5:2]};
                      partial_next = {q_head.sextet[1:0], 6'd0};
                    end
                    default: begin
                      emit_byte    = partial | {2'd0, q_head.sextet};
                      partial_next = 8'd0;
                    end
                  endcase
                  if (phase != 2'd0) begin
                    out_count_next = count_bump;
                    emit           = !count_only;
                  end
                end
              end
              default: err_next = err;
            endcase
          end
          default: err_next = err;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= 2'd0;
      pad       <= b64d_pkg::PM_DECODE;
      partial   <= 8'd0;
      out_count <= '0;
      err       <= b64d_pkg::ST_OK;
      m_tvalid  <= 1'b0;
    end else begin
      phase     <= phase_next;
      pad       <= pad_next;
      partial   <= partial_next;
      out_count <= out_count_next;
      err       <= err_next;
      if (step) begin
        m_tvalid <= emit;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_user   <= emit_status;
      out_byte   <= emit_status ? 8'd0 : emit_byte;
      out_status <= emit_status ? final_err : b64d_pkg::ST_OK;
      out_bc     <= emit_status ? b64d_pkg::BC_W'(out_count) : '0;
    end
  end

  assign m_tuser = out_user;
  assign m_tlast = out_user;
  assign m_tdata = {{(b64d_pkg::M_TDATA_W - PAY_W){1'b0}}, out_bc, out_status, out_byte};

endmodule

FILE: sv/base64_decoder_validating.sv
// Validating Base64 decoder, one character per input word, a zero character
// ends the string and yields a status word (tuser = tlast = 1) carrying the
// error code and byte count. Sustained rate is one input word per cycle while
// m_tready is high; the front end classifies each character and drops
// whitespace, a two-entry queue decouples it from the back end, which retires
// one queued character per cycle unless its single output register is held by
// m_tready low. Words pass the queue, then the output register. Configuration
// writes take effect at the next edge and should be done between strings.
module base64_decoder_validating #(
  parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [b64d_pkg::S_TDATA_W-1:0]     s_tdata,   // [7:0] char_code
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [b64d_pkg::M_TDATA_W-1:0]     m_tdata,   // [7:0] data_byte, [10:8] status,
                                                        // [26:11] byte_count, rest zero
  output logic                               m_tuser,   // is_status
  output logic                               m_tlast,
  input  logic                               cfg_we,
  input  logic [b64d_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [b64d_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [b64d_pkg::CAP_W-1:0] capacity;
  logic                       count_only;

  logic             q_push, q_full, q_pop, q_valid;
  b64d_pkg::entry_t q_entry, q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= b64d_pkg::CAPACITY_RST;
      count_only <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        b64d_pkg::CFG_CAPACITY:   capacity   <= cfg_data[b64d_pkg::CAP_W-1:0];
        b64d_pkg::CFG_COUNT_ONLY: count_only <= cfg_data[0];
        default: ;
      endcase
    end
  end

  b64d_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  b64d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (q_head)
  );

  b64d_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .capacity   (capacity),
    .count_only (count_only),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

FILE: sv/b64d_checker.sv
module b64d_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [b64d_pkg::M_TDATA_W-1:0]     m_tdata,
  input logic                               m_tuser,
  input logic                               m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  a_last_is_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tlast == m_tuser)
    else $error("tlast differs from status flag");

  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[b64d_pkg::M_TDATA_W-1:8] == '0)
    else $error("data word carries status or count");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[7:0] == 8'd0 &&
      m_tdata[10:8] <= b64d_pkg::ST_INCOMPLETE)
    else $error("malformed status word");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind base64_decoder_validating b64d_checker u_b64d_checker (.*);
